@@ rtl/assert_macros.svh @@
// Assertion helpers, sampled on clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge out of reset.
`define FDL_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a condition implies another in the same cycle.
`define FDL_ASSERT_IMP(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

`endif

@@ rtl/fdl_pkg.sv @@
package fdl_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int DELAY_BITS     = 18;
	localparam int ADDR_BITS_DEF  = 18;
	localparam int FADE_LOG2_DEF  = 5;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic        [DELAY_BITS-1:0]  delay_request;
		logic                          block_start;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic        [DELAY_BITS-1:0]  applied_delay;
		logic                          fading;
	} out_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_OUT  = 3'b010,
		PH_IN   = 3'b100
	} phase_t;

endpackage

@@ rtl/faded_variable_delay_line.sv @@
// Pipeline: an accepted input is registered in the stage 1 store read register, then in the
//   stage 2 scale register, which drives the result port.
// Throughput: one sample per cycle, set by the store's one write and one read port; the
//   input stalls only once both stages hold results the sink has not taken.
// Reset clears the pointers, fade state and pipeline valids; the store is not swept,
//   a fill tracker makes never-written entries read as zero from the first cycle.
`include "assert_macros.svh"

module faded_variable_delay_line #(
	parameter int ADDR_BITS = fdl_pkg::ADDR_BITS_DEF,
	parameter int FADE_LOG2 = fdl_pkg::FADE_LOG2_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sample_valid,
	output logic          sample_ready,
	input  fdl_pkg::in_t  sample,
	output logic          result_valid,
	input  logic          result_ready,
	output fdl_pkg::out_t result
);

	localparam int SB     = fdl_pkg::SAMPLE_BITS;
	localparam int DB     = fdl_pkg::DELAY_BITS;
	localparam int DEPTH  = 1 << ADDR_BITS;
	localparam int AMAX   = DEPTH - 1;
	localparam int CW     = FADE_LOG2;
	localparam int FADE_N = 1 << FADE_LOG2;
	localparam int GW     = CW + 1;
	localparam int PW     = SB + GW + 1;

	// control state
	logic [ADDR_BITS-1:0] wr_q, rd_q;
	logic [DB-1:0]        cur_q, tgt_q;
	fdl_pkg::phase_t      phase_q;
	logic [CW-1:0]        cnt_q;
	logic                 wrapped_q;

	logic                 acc;
	logic [DB-1:0]        req_sat;
	logic                 start_fade;
	fdl_pkg::phase_t      eff_phase;
	logic [CW-1:0]        eff_cnt;
	logic [GW-1:0]        gain;
	logic                 last_cnt;
	logic [ADDR_BITS-1:0] rd_nx;
	logic [DB-1:0]        cur_nx, tgt_nx;
	fdl_pkg::phase_t      phase_nx;
	logic [CW-1:0]        cnt_nx;

	// stage 1
	logic                 v_s1;
	logic [SB-1:0]        rdata_s1;
	logic [SB-1:0]        fwd_s1;
	logic                 use_fwd_s1, ok_s1;
	logic [GW-1:0]        gain_s1;
	logic [DB-1:0]        dly_s1;
	logic                 fad_s1;
	logic                 en_s1;

	// stage 2, drives the result port
	logic                 v_s2;
	logic signed [SB-1:0] y_s2;
	logic [DB-1:0]        dly_s2;
	logic                 fad_s2;
	logic                 en_s2;

	logic signed [SB-1:0] y_sel;
	logic signed [PW-1:0] prod, scaled;

	logic [SB-1:0]        store_mem [DEPTH];

	// ---------------- stage 0: control, store write and read ----------------
	assign acc = sample_valid && sample_ready;

	always_comb begin
		if (ADDR_BITS < DB && 32'(sample.delay_request) > AMAX) begin
			req_sat = DB'(AMAX);
		end else begin
			req_sat = sample.delay_request;
		end
	end

	assign start_fade = (phase_q == fdl_pkg::PH_IDLE) && sample.block_start && (req_sat != cur_q);
	assign eff_phase  = start_fade ? fdl_pkg::PH_OUT : phase_q;
	assign eff_cnt    = start_fade ? '0 : cnt_q;
	assign last_cnt   = (eff_cnt == CW'(FADE_N - 1));

	always_comb begin
		rd_nx    = rd_q + 1'b1;
		cur_nx   = cur_q;
		tgt_nx   = start_fade ? req_sat : tgt_q;
		phase_nx = eff_phase;
		cnt_nx   = eff_cnt;
		gain     = GW'(FADE_N);
		unique case (eff_phase)
			fdl_pkg::PH_OUT: begin
				gain = GW'(FADE_N) - GW'(eff_cnt);
				if (last_cnt) begin
					// switch tap: read pointer jumps to the new delay
					rd_nx    = rd_q + 1'b1 + ADDR_BITS'(cur_q) - ADDR_BITS'(tgt_nx);
					cur_nx   = tgt_nx;
					phase_nx = fdl_pkg::PH_IN;
					cnt_nx   = '0;
				end else begin
					cnt_nx = eff_cnt + 1'b1;
				end
			end
			fdl_pkg::PH_IN: begin
				gain = GW'(eff_cnt);
				if (last_cnt) begin
					phase_nx = fdl_pkg::PH_IDLE;
					cnt_nx   = '0;
				end else begin
					cnt_nx = eff_cnt + 1'b1;
				end
			end
			fdl_pkg::PH_IDLE: begin
				gain = GW'(FADE_N);
			end
			default: begin
				gain = GW'(FADE_N);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q      <= '0;
			rd_q      <= '0;
			cur_q     <= '0;
			tgt_q     <= '0;
			phase_q   <= fdl_pkg::PH_IDLE;
			cnt_q     <= '0;
			wrapped_q <= 1'b0;
		end else if (acc) begin
			wr_q    <= wr_q + 1'b1;
			rd_q    <= rd_nx;
			cur_q   <= cur_nx;
			tgt_q   <= tgt_nx;
			phase_q <= phase_nx;
			cnt_q   <= cnt_nx;
			if (wr_q == '1) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			store_mem[wr_q] <= sample.sample_in;
		end
		if (en_s1) begin
			rdata_s1 <= store_mem[rd_q];
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			fwd_s1     <= sample.sample_in;
			// same-cycle write and read of one entry: take the incoming sample
			use_fwd_s1 <= (rd_q == wr_q);
			// entries not yet written since reset read as zero
			ok_s1      <= wrapped_q || (rd_q < wr_q);
			gain_s1    <= gain;
			dly_s1     <= cur_nx;
			fad_s1     <= (eff_phase != fdl_pkg::PH_IDLE);
		end
	end

	// ---------------- stage 2: scale ----------------
	always_comb begin
		if (use_fwd_s1) begin
			y_sel = signed'(fwd_s1);
		end else if (ok_s1) begin
			y_sel = signed'(rdata_s1);
		end else begin
			y_sel = '0;
		end
	end

	// fade length is a power of two, so the floor divide is an arithmetic shift
	assign prod   = PW'(y_sel) * PW'(signed'({1'b0, gain_s1}));
	assign scaled = prod >>> CW;

	// stall chain: a stage moves when it is empty or its successor moves
	assign en_s2        = !v_s2 || result_ready;
	assign en_s1        = !v_s1 || en_s2;
	assign sample_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			y_s2   <= scaled[SB-1:0];
			dly_s2 <= dly_s1;
			fad_s2 <= fad_s1;
		end
	end

	assign result_valid         = v_s2;
	assign result.sample_out    = y_s2;
	assign result.applied_delay = dly_s2;
	assign result.fading        = fad_s2;

	// ---------------- assertions ----------------
	`FDL_ASSERT(a_tap_offset, rd_q == wr_q - ADDR_BITS'(cur_q), "read pointer off current delay")
	`FDL_ASSERT_IMP(a_idle_count, phase_q == fdl_pkg::PH_IDLE, cnt_q == '0, "count nonzero in idle")
	`FDL_ASSERT_IMP(a_fade_in_delay, phase_q == fdl_pkg::PH_IN, cur_q == tgt_q, "delay not switched in fade-in")

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;

	localparam int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS;
	localparam int DELAY_BITS  = fdl_pkg::DELAY_BITS;
	localparam int ADDR_W    = fdl_pkg::ADDR_BITS_DEF;
	localparam int FADE      = 1 << fdl_pkg::FADE_LOG2_DEF;
	localparam int DEPTH     = 1 << ADDR_W;
	localparam int ADDR_MASK = DEPTH - 1;
	localparam int MAX_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 50;
	localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	fdl_pkg::in_t  sample_item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	fdl_pkg::out_t result_item;

	faded_variable_delay_line u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Delay line state as predicted on the testbench side
	logic signed [SAMPLE_BITS-1:0] tap_store [DEPTH];
	logic [ADDR_W-1:0]     wr_idx;
	logic [ADDR_W-1:0]     rd_idx;
	logic [DELAY_BITS-1:0] cur_delay;
	logic [DELAY_BITS-1:0] tgt_delay;
	fdl_pkg::phase_t       fade_phase;
	int                    fade_pos;

	fdl_pkg::out_t tap_outputs_due [$];
	int   err_count = 0;
	int   cycle_count = 0;
	bit   tx_gaps_on = 1'b0;
	bit   rx_stalls_on = 1'b0;
	int   rx_hold_cycles = 0;

	function automatic void clear_delay_line();
		for (int i = 0; i < DEPTH; i++)
			tap_store[i] = '0;
		wr_idx     = '0;
		rd_idx     = '0;
		cur_delay  = '0;
		tgt_delay  = '0;
		fade_phase = fdl_pkg::PH_IDLE;
		fade_pos   = 0;
	endfunction

	function automatic fdl_pkg::out_t compute_tap_output(input fdl_pkg::in_t s);
		logic [DELAY_BITS-1:0] req;
		longint tap;
		longint prod;
		longint quo;
		int     gain;
		logic   was_fading;
		fdl_pkg::out_t r;
		req = s.delay_request;
		if (req > ADDR_MASK)
			req = DELAY_BITS'(ADDR_MASK);
		if (fade_phase == fdl_pkg::PH_IDLE && s.block_start && req != cur_delay) begin
			tgt_delay  = req;
			fade_phase = fdl_pkg::PH_OUT;
			fade_pos   = 0;
		end
		tap_store[wr_idx] = s.sample_in;
		tap = tap_store[rd_idx];
		was_fading = (fade_phase != fdl_pkg::PH_IDLE);
		gain = FADE;
		if (fade_phase == fdl_pkg::PH_OUT)
			gain = FADE - fade_pos;
		else if (fade_phase == fdl_pkg::PH_IN)
			gain = fade_pos;
		// floor division, not truncation toward zero
		prod = tap * gain;
		quo = prod / FADE;
		if (prod < 0 && quo * FADE != prod)
			quo = quo - 1;
		wr_idx = wr_idx + 1'b1;
		rd_idx = rd_idx + 1'b1;
		if (fade_phase == fdl_pkg::PH_OUT) begin
			fade_pos++;
			if (fade_pos >= FADE) begin
				// switch the tap right after the last fade-out sample
				rd_idx     = rd_idx + ADDR_W'(cur_delay) - ADDR_W'(tgt_delay);
				cur_delay  = tgt_delay;
				fade_phase = fdl_pkg::PH_IN;
				fade_pos   = 0;
			end
		end else if (fade_phase == fdl_pkg::PH_IN) begin
			fade_pos++;
			if (fade_pos >= FADE) begin
				fade_phase = fdl_pkg::PH_IDLE;
				fade_pos   = 0;
			end
		end
		r.sample_out    = quo[SAMPLE_BITS-1:0];
		r.applied_delay = cur_delay;
		r.fading        = was_fading;
		return r;
	endfunction

	// mostly short, now and then long
	function automatic int rand_stretch();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_tx_gap();
		if (!tx_gaps_on || $urandom_range(0, 1) == 0)
			return 0;
		return rand_stretch();
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			2: return SAMPLE_BITS'($signed($urandom_range(0, 64)) - 32);
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	function automatic logic [DELAY_BITS-1:0] rand_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return DELAY_BITS'($urandom_range(0, 40));
		else if (r < 50)
			return cur_delay;
		else if (r < 65)
			return DELAY_BITS'($urandom_range(41, 2000));
		else if (r < 80)
			return DELAY_BITS'($urandom());
		else if (r < 90)
			return DELAY_MAX - DELAY_BITS'($urandom_range(0, 1));
		return '0;
	endfunction

	// one transfer on the sample channel; returns in the step of the accepting edge
	task automatic send_sample(input fdl_pkg::in_t item, input int gap);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_item  <= item;
		do @(posedge clk); while (!sample_ready);
		tap_outputs_due.push_back(compute_tap_output(item));
	endtask

	task automatic send_fields(input logic [SAMPLE_BITS-1:0] smp,
			input logic [DELAY_BITS-1:0] req, input logic blk);
		fdl_pkg::in_t item;
		item.sample_in     = smp;
		item.delay_request = req;
		item.block_start   = blk;
		send_sample(item, pick_tx_gap());
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		do @(posedge clk); while (tap_outputs_due.size() != 0);
	endtask

	task automatic check_output(input fdl_pkg::out_t got);
		fdl_pkg::out_t want;
		if (tap_outputs_due.size() == 0) begin
			$error("unexpected result: sample_out %0d applied_delay %0d fading %0b",
				got.sample_out, got.applied_delay, got.fading);
			err_count++;
			return;
		end
		want = tap_outputs_due.pop_front();
		if (got.sample_out !== want.sample_out) begin
			$error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
			err_count++;
		end
		if (got.applied_delay !== want.applied_delay) begin
			$error("applied_delay: expected %0d, got %0d",
				want.applied_delay, got.applied_delay);
			err_count++;
		end
		if (got.fading !== want.fading) begin
			$error("fading: expected %0b, got %0b", want.fading, got.fading);
			err_count++;
		end
	endtask

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready)
				check_output(result_item);
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if (rx_stalls_on && $urandom_range(0, 3) == 0)
					stall_left = rand_stretch();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// delay 0 passes extremes straight through; request equal to current starts nothing
	task automatic test_passthrough();
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		send_fields({1'b0, {(SAMPLE_BITS-1){1'b1}}}, '0, 1'b1);
		send_fields({1'b1, {(SAMPLE_BITS-1){1'b0}}}, '0, 1'b0);
		send_fields('0, '0, 1'b0);
		send_fields('1, '0, 1'b1);
		send_fields(SAMPLE_BITS'(1), '0, 1'b0);
	endtask

	task automatic test_off_block_start();
		send_fields(SAMPLE_BITS'(12345), DELAY_BITS'(7), 1'b0);
		send_fields(SAMPLE_BITS'(-12345), DELAY_MAX, 1'b0);
	endtask

	// change to delay 3, with requests arriving mid-fade, through the switch and fade-in
	task automatic test_fade_switch();
		send_fields({1'b0, {(SAMPLE_BITS-1){1'b1}}}, DELAY_BITS'(3), 1'b1);
		for (int i = 1; i < 2 * FADE; i++) begin
			if (i == 5)
				send_fields({1'b1, {(SAMPLE_BITS-1){1'b0}}}, DELAY_MAX, 1'b1);
			else if (i == FADE + 3)
				send_fields(rand_sample(), DELAY_BITS'(9), 1'b1);
			else if (i % 4 == 0)
				send_fields('1, DELAY_BITS'(3), 1'b0);
			else
				send_fields(rand_sample(), DELAY_BITS'(3), 1'b0);
		end
	endtask

	// sink holds off long enough for the pipeline to fill and stall the input
	task automatic test_output_backpressure();
		tx_gaps_on     = 1'b0;
		rx_hold_cycles = 400;
		for (int i = 0; i < 40; i++)
			send_fields(rand_sample(), cur_delay, 1'b0);
	endtask

	task automatic test_sender_pause();
		wait_drained();
		tx_gaps_on = 1'b1;
		send_fields(rand_sample(), DELAY_BITS'(2), 1'b1);
		for (int i = 0; i < 10; i++)
			send_fields(rand_sample(), DELAY_BITS'(2), 1'b0);
	endtask

	// host-style blocks: mostly, request held and block_start on the first sample
	task automatic test_random_blocks(input int n_items);
		int sent;
		int blk_len;
		int r;
		logic [DELAY_BITS-1:0] req;
		fdl_pkg::in_t item;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 5) == 0)
				tx_gaps_on = !tx_gaps_on;
			if ($urandom_range(0, 5) == 0)
				rx_stalls_on = !rx_stalls_on;
			r = $urandom_range(0, 9);
			if (r < 7)
				blk_len = $urandom_range(40, 120);
			else if (r < 9)
				blk_len = $urandom_range(1, 16);
			else
				blk_len = $urandom_range(128, 200);
			req = rand_delay();
			for (int i = 0; i < blk_len; i++) begin
				item.sample_in     = rand_sample();
				item.delay_request = req;
				item.block_start   = (i == 0);
				if ($urandom_range(0, 19) == 0) begin
					item.delay_request = DELAY_BITS'($urandom());
					item.block_start   = $urandom_range(0, 1);
				end
				send_sample(item, pick_tx_gap());
			end
			sent += blk_len;
		end
	endtask

	initial begin
		clear_delay_line();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_off_block_start();
		test_fade_switch();
		test_output_backpressure();
		test_sender_pause();
		test_random_blocks(1650);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
